[src/pwg_pkg.sv]
// Shared types and constants for the periodic waveform generator.
// Holds the mode codes, register indexes and the sine table builder.
// No dependencies.
package pwg_pkg;

	typedef enum logic [2:0] {
		MODE_SINE     = 3'd0,
		MODE_TRIANGLE = 3'd1,
		MODE_SQUARE   = 3'd2,
		MODE_SAW      = 3'd3,
		MODE_INV_SAW  = 3'd4
	} wave_mode_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_WAVE_MODE    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_LEVEL   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PHASE_OFFSET = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_FREQUENCY    = 3'd4;

	localparam logic signed [15:0] BASE_LEVEL_RESET = 16'sd2048;

	// Shape is Q1.15 on 17 bits so that +1.0 fits
	localparam int SHAPE_W = 17;
	localparam logic [SHAPE_W-1:0] SHAPE_ONE = 17'h08000;

	// pi/2 in Q30
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// Divisors of the odd Taylor terms: (2n)(2n+1) for n = 1..6
	localparam longint unsigned SERIES_DIV [6] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156
	};

	// One table entry from its angle x in Q30: Taylor series to x^13,
	// then round to Q1.15 and clamp to +1.0.
	function automatic logic [SHAPE_W-1:0] sine_entry(input longint unsigned x);
		longint unsigned t;
		longint          s;
		longint          r;
		t = x;
		s = longint'(x);
		for (int n = 0; n < 6; n++) begin
			t = (t * x) >> 30;
			t = (t * x) >> 30;
			t = t / SERIES_DIV[n];
			if ((n % 2) == 0) begin
				s = s - longint'(t);
			end else begin
				s = s + longint'(t);
			end
		end
		if (s < 0) begin
			s = 0;
		end
		r = (s + 64'sd16384) >>> 15;
		if (r > 64'sd32768) begin
			r = 64'sd32768;
		end
		return SHAPE_W'(r);
	endfunction

endpackage

[src/pwg_shape.sv]
// Phase-to-shape section of the waveform generator: two pipeline stages.
// Stage 2 forms the cycle position, stage 3 looks up or builds the shape.
// Depends on pwg_pkg.
module pwg_shape #(
	parameter int SINE_TABLE_DEPTH = 256,
	parameter int PHASE_BITS       = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [31:0]                         phase_step,
	input  logic [15:0]                         phase_offset,
	input  pwg_pkg::wave_mode_t                 wave_mode,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [pwg_pkg::SHAPE_W-1:0]  shape
);

	localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
	localparam int ADDR_W  = IDX_W + 1;
	localparam int PROD_W  = 30 + IDX_W;
	localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - PHASE_BITS)) - 32'd1);
	localparam logic [ADDR_W-1:0] DEPTH_A = ADDR_W'(SINE_TABLE_DEPTH);
	localparam logic [PROD_W-1:0] DEPTH_P = PROD_W'(SINE_TABLE_DEPTH);

	// Quarter-wave table; the entry at the full depth is +1.0 and is handled apart
	logic [pwg_pkg::SHAPE_W-1:0] sine_rom [SINE_TABLE_DEPTH];

	for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
		localparam longint unsigned ANGLE =
			(longint'(k) * pwg_pkg::HALF_PI_Q30) / SINE_TABLE_DEPTH;
		assign sine_rom[k] = pwg_pkg::sine_entry(ANGLE);
	end

	logic              valid_s2;
	logic              ready_s2;
	logic [1:0]        quad_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic [15:0]       v_s2;

	logic              valid_s3;
	logic signed [pwg_pkg::SHAPE_W-1:0] shape_s3;

	logic [31:0]       pos;
	logic [PROD_W-1:0] idx_prod;

	assign pos      = ({phase_offset, 16'h0000} + phase_step) & PHASE_MASK;
	assign idx_prod = PROD_W'(pos[29:0]) * DEPTH_P;

	assign ready_s2 = !valid_s3 || out_ready;
	assign in_ready = !valid_s2 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			quad_s2 <= pos[31:30];
			idx_s2  <= idx_prod[PROD_W-1:30];
			v_s2    <= pos[31:16];
		end
	end

	// Stage 3: shape from quadrant, table index and top phase bits
	logic [ADDR_W-1:0]            addr;
	logic [pwg_pkg::SHAPE_W-1:0]  rom_val;
	logic [pwg_pkg::SHAPE_W-1:0]  sine_val;
	logic [pwg_pkg::SHAPE_W-1:0]  v_ext;
	logic [pwg_pkg::SHAPE_W-1:0]  half_v;
	logic signed [pwg_pkg::SHAPE_W-1:0] shape_next;

	assign addr  = quad_s2[0] ? (DEPTH_A - {1'b0, idx_s2}) : {1'b0, idx_s2};
	assign v_ext = {1'b0, v_s2};
	assign half_v = {2'b00, v_s2[15:1]};

	always_comb begin
		if (addr == DEPTH_A) begin
			rom_val = pwg_pkg::SHAPE_ONE;
		end else begin
			rom_val = sine_rom[addr[IDX_W-1:0]];
		end
		sine_val = quad_s2[1] ? (~rom_val + 1'b1) : rom_val;
	end

	always_comb begin
		case (wave_mode)
			pwg_pkg::MODE_TRIANGLE: begin
				shape_next = v_s2[15] ? $signed(17'h10000 - v_ext) : $signed(v_ext);
			end
			pwg_pkg::MODE_SQUARE: begin
				shape_next = v_s2[15] ? -17'sd32768 : 17'sd32768;
			end
			pwg_pkg::MODE_SAW: begin
				shape_next = $signed(half_v);
			end
			pwg_pkg::MODE_INV_SAW: begin
				shape_next = $signed(pwg_pkg::SHAPE_ONE - half_v);
			end
			default: begin
				shape_next = $signed(sine_val);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s2) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s2) begin
			shape_s3 <= shape_next;
		end
	end

	assign out_valid = valid_s3;
	assign shape     = shape_s3;

endmodule

[src/periodic_waveform_generator_top.sv]
// Top level of the periodic waveform generator: stream ports, config registers,
// the phase multiply, amplitude multiply and output add. Depends on pwg_pkg, pwg_shape.
//
// Each time stamp word on the input stream gives one sample word on the output:
// base_level + amplitude * shape(phase_offset + frequency * time_ms), in signed
// Q5.12. A new word is taken every clock unless the output stalls; a word
// passes through five register stages (phase multiply, phase position, shape,
// amplitude multiply, output add). Stages hold their word under back-pressure
// and empty stages still fill, so input flows while a result waits.
// Configuration is written through cfg_we/cfg_index/cfg_wdata and must be left
// alone while words are in flight.
module periodic_waveform_generator_top #(
	parameter int SINE_TABLE_DEPTH = 256,
	parameter int PHASE_BITS       = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [31:0]                         s_axis_tdata,  // [31:0] time_ms
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [23:0]                         m_axis_tdata,  // [17:0] wave_value, rest zero
	input  logic                                cfg_we,
	input  logic [pwg_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [pwg_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	pwg_pkg::wave_mode_t wave_mode_q;
	logic signed [15:0]  base_level_q;
	logic signed [15:0]  amplitude_q;
	logic [15:0]         phase_offset_q;
	logic [31:0]         frequency_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_mode_q    <= pwg_pkg::MODE_SINE;
			base_level_q   <= pwg_pkg::BASE_LEVEL_RESET;
			amplitude_q    <= '0;
			phase_offset_q <= '0;
			frequency_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pwg_pkg::REG_WAVE_MODE:    wave_mode_q <= pwg_pkg::wave_mode_t'(cfg_wdata[2:0]);
				pwg_pkg::REG_BASE_LEVEL:   base_level_q   <= $signed(cfg_wdata[15:0]);
				pwg_pkg::REG_AMPLITUDE:    amplitude_q    <= $signed(cfg_wdata[15:0]);
				pwg_pkg::REG_PHASE_OFFSET: phase_offset_q <= cfg_wdata[15:0];
				pwg_pkg::REG_FREQUENCY:    frequency_q    <= cfg_wdata[31:0];
				default: begin
				end
			endcase
		end
	end

	// Stage 1: phase advance, low 32 bits of frequency * time (wraps)
	logic        valid_s1;
	logic        ready_s1;
	logic [31:0] step_s1;
	logic [31:0] step_full;

	assign step_full = frequency_q * s_axis_tdata;

	logic shape_in_ready;
	logic shape_valid;
	logic shape_ready;
	logic signed [pwg_pkg::SHAPE_W-1:0] shape;

	assign ready_s1      = !valid_s1 || shape_in_ready;
	assign s_axis_tready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_axis_tvalid) begin
			step_s1 <= step_full;
		end
	end

	pwg_shape #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.PHASE_BITS       (PHASE_BITS)
	) u_shape (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (valid_s1),
		.in_ready     (shape_in_ready),
		.phase_step   (step_s1),
		.phase_offset (phase_offset_q),
		.wave_mode    (wave_mode_q),
		.out_valid    (shape_valid),
		.out_ready    (shape_ready),
		.shape        (shape)
	);

	// Stage 4: amplitude times shape, with the rounding half added
	logic               valid_s4;
	logic               ready_s4;
	logic signed [33:0] prod_s4;
	logic signed [33:0] prod_next;

	assign prod_next = 34'(amplitude_q * shape) + 34'sd16384;

	// Stage 5: drop 15 fraction bits (floor) and add base
	logic               valid_s5;
	logic               ready_s5;
	logic signed [17:0] result_s5;
	logic signed [33:0] scaled;
	logic signed [17:0] result_next;

	assign scaled      = prod_s4 >>> 15;
	assign result_next = 18'(base_level_q) + scaled[17:0];

	assign ready_s5    = !valid_s5 || m_axis_tready;
	assign ready_s4    = !valid_s4 || ready_s5;
	assign shape_ready = ready_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s4) begin
				valid_s4 <= shape_valid;
			end
			if (ready_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && shape_valid) begin
			prod_s4 <= prod_next;
		end
		if (ready_s5 && valid_s4) begin
			result_s5 <= result_next;
		end
	end

	assign m_axis_tvalid = valid_s5;
	assign m_axis_tdata  = {6'b000000, result_s5};

endmodule

[sim/wave_checker.sv]
`timescale 1ns / 100ps
// Checker for the periodic waveform generator: tracks register writes, predicts a
// wave word for every time stamp taken and compares it with the output stream.
// Depends on pwg_pkg for the mode codes and register indexes.
module wave_checker #(
	parameter int SINE_TABLE_DEPTH = 256,
	parameter int PHASE_BITS       = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [31:0]                     s_tdata,   // [31:0] time_ms
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [23:0]                     m_tdata,   // [17:0] wave_value, [23:18] zero
	input  logic                            cfg_we,
	input  logic [pwg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pwg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output int                              errors,
	output int                              outstanding
);

	// pi/2 in Q30
	localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

	int                 quarter_sine [SINE_TABLE_DEPTH+1];
	logic [2:0]         mode_r;
	logic signed [15:0] base_r;
	logic signed [15:0] amp_r;
	logic [15:0]        phase_r;
	logic [31:0]        freq_r;
	logic [17:0]        wave_q [$];
	logic [17:0]        want;
	int                 err_tally;

	// Taylor series of sin to x^13 in Q30, rounded to Q1.15 and clamped to +1.0
	function automatic int sine_q15(input int k);
		longint unsigned x;
		longint unsigned t;
		longint          s;
		longint          r;
		x = (64'(k) * QUARTER_TURN_Q30) / 64'(SINE_TABLE_DEPTH);
		t = x;
		s = longint'(x);
		for (int n = 1; n <= 6; n++) begin
			t = (t * x) >> 30;
			t = (t * x) >> 30;
			t = t / 64'((2 * n) * (2 * n + 1));
			if ((n % 2) == 1) begin
				s = s - longint'(t);
			end else begin
				s = s + longint'(t);
			end
		end
		if (s < 0) begin
			s = 0;
		end
		r = (s + 64'sd16384) >>> 15;
		if (r > 64'sd32768) begin
			r = 64'sd32768;
		end
		return int'(r);
	endfunction

	initial begin
		for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
			quarter_sine[k] = sine_q15(k);
		end
		quarter_sine[SINE_TABLE_DEPTH] = 32768;
	end

	// Unit shape in Q1.15 for the cycle position u; unknown codes take the sine
	function automatic int shape_of(input logic [31:0] u);
		logic [15:0] v;
		logic [63:0] idx;
		int          mag;
		v = u[31:16];
		case (mode_r)
			pwg_pkg::MODE_TRIANGLE: return v[15] ? 65536 - int'(v) : int'(v);
			pwg_pkg::MODE_SQUARE:   return v[15] ? -32768 : 32768;
			pwg_pkg::MODE_SAW:      return int'(v >> 1);
			pwg_pkg::MODE_INV_SAW:  return 32768 - int'(v >> 1);
			default: begin
				idx = ({34'd0, u[29:0]} * 64'(SINE_TABLE_DEPTH)) >> 30;
				if (idx > 64'(SINE_TABLE_DEPTH)) begin
					idx = 64'(SINE_TABLE_DEPTH);
				end
				mag = u[30] ? quarter_sine[SINE_TABLE_DEPTH - int'(idx)] : quarter_sine[int'(idx)];
				return u[31] ? -mag : mag;
			end
		endcase
	endfunction

	function automatic logic [17:0] predict_wave(input logic [31:0] stamp);
		logic [31:0] u;
		longint      prod;
		longint      res;
		u = {phase_r, 16'h0000} + freq_r * stamp;
		u = u & (32'hFFFF_FFFF << (32 - PHASE_BITS));
		// round the Q3.12 x Q1.15 product to Q3.12, half up
		prod = longint'(amp_r) * longint'(shape_of(u)) + 64'sd16384;
		res = longint'(base_r) + (prod >>> 15);
		return res[17:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_r = pwg_pkg::MODE_SINE;
			base_r = pwg_pkg::BASE_LEVEL_RESET;
			amp_r = '0;
			phase_r = '0;
			freq_r = '0;
			wave_q.delete();
			err_tally = 0;
			errors <= 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (wave_q.size() == 0) begin
					err_tally++;
					$error("wave_value: expected none, got %0d", $signed(m_tdata[17:0]));
				end else begin
					want = wave_q.pop_front();
					if (m_tdata[17:0] !== want) begin
						err_tally++;
						$error("wave_value: expected %0d, got %0d", $signed(want),
							$signed(m_tdata[17:0]));
					end
					if (m_tdata[23:18] !== 6'd0) begin
						err_tally++;
						$error("tdata padding: expected 0, got %0h", m_tdata[23:18]);
					end
				end
			end
			// predict with the settings in force before this edge
			if (s_tvalid && s_tready) begin
				wave_q.push_back(predict_wave(s_tdata));
			end
			if (cfg_we) begin
				case (cfg_index)
					pwg_pkg::REG_WAVE_MODE:    mode_r = cfg_wdata[2:0];
					pwg_pkg::REG_BASE_LEVEL:   base_r = cfg_wdata[15:0];
					pwg_pkg::REG_AMPLITUDE:    amp_r = cfg_wdata[15:0];
					pwg_pkg::REG_PHASE_OFFSET: phase_r = cfg_wdata[15:0];
					pwg_pkg::REG_FREQUENCY:    freq_r = cfg_wdata[31:0];
					default: ;
				endcase
			end
			errors <= err_tally;
			outstanding <= wave_q.size();
		end
	end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top for the periodic waveform generator: clock, reset, register
// programming and time stamp stimulus with random idling on both streams.
// Depends on pwg_pkg, periodic_waveform_generator_top and wave_checker.
module tb_top;

	localparam int DEPTH        = 256;
	localparam int PBITS        = 32;
	localparam int TOTAL_ITEMS  = 550;
	localparam int CYCLE_LIMIT  = 400000;

	localparam logic [31:0] EDGE_FREQ [8] = '{
		32'h4000_0000, 32'hC000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
		32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0001, 32'h0100_0000
	};
	localparam logic [15:0] EDGE_PHASE [8] = '{
		16'hC000, 16'hFFFF, 16'h4000, 16'h8000,
		16'h0000, 16'h0001, 16'h7FFF, 16'hFFFF
	};

	logic                            clk;
	logic                            arst_n;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [31:0]                     s_axis_tdata;   // [31:0] time_ms
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	logic [23:0]                     m_axis_tdata;   // [17:0] wave_value, [23:18] zero
	logic                            cfg_we;
	logic [pwg_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [pwg_pkg::CFG_DATA_W-1:0]  cfg_wdata;

	int          errors;
	int          outstanding;
	int          cycles;
	int          items_sent;
	int          settings;
	logic [31:0] stamp_q [$];

	periodic_waveform_generator_top #(
		.SINE_TABLE_DEPTH(DEPTH),
		.PHASE_BITS      (PBITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	wave_checker #(
		.SINE_TABLE_DEPTH(DEPTH),
		.PHASE_BITS      (PBITS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.errors     (errors),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Output stall pattern: free running, coin toss, mostly stalled, or periodic
	initial begin
		int style;
		int span;
		m_axis_tready <= 1'b0;
		forever begin
			style = $urandom_range(0, 3);
			span = $urandom_range(4, 40);
			for (int k = 0; k < span; k++) begin
				@(posedge clk);
				case (style)
					0:       m_axis_tready <= 1'b1;
					1:       m_axis_tready <= 1'($urandom_range(0, 1));
					2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= ((k % 4) != 3);
				endcase
			end
		end
	end

	function automatic logic [15:0] pick_level();
		case ($urandom_range(0, 7))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Hold until every expected word is out, then let the pipeline settle
	task automatic wait_idle();
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic program_regs(input logic [2:0] mode, input logic [15:0] base,
		input logic [15:0] amp, input logic [15:0] phase, input logic [31:0] freq);
		cfg_we <= 1'b1;
		cfg_index <= pwg_pkg::REG_WAVE_MODE;
		cfg_wdata <= {29'd0, mode};
		@(posedge clk);
		cfg_index <= pwg_pkg::REG_BASE_LEVEL;
		cfg_wdata <= {{16{base[15]}}, base};
		@(posedge clk);
		cfg_index <= pwg_pkg::REG_AMPLITUDE;
		cfg_wdata <= {{16{amp[15]}}, amp};
		@(posedge clk);
		cfg_index <= pwg_pkg::REG_PHASE_OFFSET;
		cfg_wdata <= {16'd0, phase};
		@(posedge clk);
		cfg_index <= pwg_pkg::REG_FREQUENCY;
		cfg_wdata <= freq;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	// Send the queued time stamps in bursts with random gaps
	task automatic play_stamps();
		int burst;
		int gap;
		while (stamp_q.size() > 0) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && stamp_q.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= stamp_q.pop_front();
				@(posedge clk);
				while (!s_axis_tready) begin
					@(posedge clk);
				end
				items_sent++;
				burst--;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: gap = 0;
				9:             gap = $urandom_range(10, 25);
				default:       gap = $urandom_range(1, 4);
			endcase
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b0;
	endtask

	initial begin
		int          target;
		int          span;
		logic [2:0]  mode;
		logic [31:0] freq;
		logic [31:0] clock_ms;
		items_sent = 0;
		settings = 0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_index <= pwg_pkg::REG_WAVE_MODE;
		cfg_wdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: zero amplitude leaves the base level alone
		stamp_q.push_back(32'h0000_0000);
		stamp_q.push_back(32'hFFFF_FFFF);
		play_stamps();

		// Every mode code with full-scale base and amplitude, edge phases and frequencies
		for (int m = 0; m < 8; m++) begin
			mode = 3'(m);
			wait_idle();
			program_regs(mode, mode[1] ? 16'h8000 : 16'h7FFF, mode[0] ? 16'h7FFF : 16'h8000,
				EDGE_PHASE[m], EDGE_FREQ[m]);
			stamp_q.push_back(32'h0000_0000);
			stamp_q.push_back(32'h0000_0001);
			stamp_q.push_back(32'hFFFF_FFFF);
			play_stamps();
		end

		target = TOTAL_ITEMS;
		while (items_sent < target) begin
			mode = 3'($urandom_range(0, 7));
			case ($urandom_range(0, 5))
				0:       freq = 32'h8000_0000;
				1:       freq = 32'h7FFF_FFFF;
				2:       freq = 32'($urandom_range(1, 1 << 20));
				3:       freq = -32'($urandom_range(1, 1 << 20));
				default: freq = $urandom;
			endcase
			wait_idle();
			program_regs(mode, pick_level(), pick_level(), 16'($urandom), freq);
			span = $urandom_range(10, 60);
			if (span > target - items_sent) begin
				span = target - items_sent;
			end
			clock_ms = $urandom;
			repeat (span) begin
				case ($urandom_range(0, 3))
					0: stamp_q.push_back($urandom);
					1: begin
						clock_ms = clock_ms + 32'd1;
						stamp_q.push_back(clock_ms);
					end
					2: stamp_q.push_back(32'hFFFF_FFFF - 32'($urandom_range(0, 15)));
					default: stamp_q.push_back(32'($urandom_range(0, 255)));
				endcase
			end
			play_stamps();
		end

		wait_idle();
		$display("Sent %0d time stamps under %0d register settings covering all eight mode codes,",
			items_sent, settings);
		$display("full-scale base and amplitude, negative and edge frequencies and time wrap.");
		if (errors == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
